// ===== rtl/core/swms_pkg.sv =====
package swms_pkg;

	localparam int MAX_WINDOW  = 256;
	localparam int SAMPLE_BITS = 24;
	localparam int IDX_W       = $clog2(MAX_WINDOW);
	localparam int CNT_W       = IDX_W + 1;
	localparam int MED_W       = SAMPLE_BITS + 1;
	localparam int PROD_W      = 2 * SAMPLE_BITS;
	localparam int SUM_W       = 32;
	localparam int SQ_W        = 55;

	localparam logic [CNT_W-1:0] LEN_RESET = CNT_W'(96);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	// broadcast to every cell of the sorted chain
	typedef struct packed {
		logic    remove;
		logic    insert;
		sample_t key;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/swms_cell.sv =====
module swms_cell (
	input  logic                 clk,
	input  swms_pkg::cell_ctrl_t ctrl,
	input  logic                 occ,
	input  swms_pkg::sample_t    left_val,
	input  logic                 left_gt,
	input  swms_pkg::sample_t    right_val,
	output swms_pkg::sample_t    val,
	output logic                 gt
);
	import swms_pkg::*;

	sample_t val_q;
	logic    ge;

	// empty cells count as +infinity for insertion
	assign ge  = occ && (val_q >= ctrl.key);
	assign gt  = !occ || (val_q > ctrl.key);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.remove && ge) begin
			val_q <= right_val;
		end else if (ctrl.insert && gt) begin
			// first cell above the key takes the key, the rest take the left value
			val_q <= left_gt ? left_val : ctrl.key;
		end
	end

endmodule

// ===== rtl/core/swms_chain.sv =====
module swms_chain (
	input  logic                             clk,
	input  swms_pkg::cell_ctrl_t             ctrl,
	input  logic [swms_pkg::CNT_W-1:0]       fill,
	output swms_pkg::sample_t                min_val,
	output swms_pkg::sample_t                max_val,
	output swms_pkg::sample_t                mid_lo,
	output swms_pkg::sample_t                mid_hi
);
	import swms_pkg::*;

	sample_t            cell_val [MAX_WINDOW];
	logic               cell_gt  [MAX_WINDOW];
	logic [IDX_W-1:0]   hi_idx;
	logic [IDX_W-1:0]   lo_idx;
	logic [IDX_W-1:0]   max_idx;

	for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
		sample_t lv;
		sample_t rv;
		logic    lg;
		logic    occ;

		assign occ = fill > CNT_W'(j);
		if (j == 0) begin : g_first
			assign lv = '0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = cell_val[j-1];
			assign lg = cell_gt[j-1];
		end
		if (j == MAX_WINDOW - 1) begin : g_last
			assign rv = '0;
		end else begin : g_inner
			assign rv = cell_val[j+1];
		end

		swms_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (occ),
			.left_val  (lv),
			.left_gt   (lg),
			.right_val (rv),
			.val       (cell_val[j]),
			.gt        (cell_gt[j])
		);
	end

	// odd count: both taps sit on the middle cell
	assign hi_idx  = fill[IDX_W:1];
	assign lo_idx  = fill[0] ? hi_idx : hi_idx - IDX_W'(1);
	assign max_idx = fill[IDX_W-1:0] - IDX_W'(1);

	assign min_val = cell_val[0];
	assign max_val = cell_val[max_idx];
	assign mid_lo  = cell_val[lo_idx];
	assign mid_hi  = cell_val[hi_idx];

endmodule

// ===== rtl/core/sliding_window_median_stats.sv =====
// sliding window median and sums over signed nanosecond offsets
// input channel: in_valid/in_ready with operation (add sample or clear) and
// offset; every accepted beat gives exactly one result beat on
// out_valid/out_ready with count, twice the median, min, max, sum and sum of squares
// config: cfg_we writes cfg_wdata into the window length (0 acts as 1, above
// 256 acts as 256) and empties the window; write only while the block is idle
// samples sit in a 256-entry ring memory and in a chain of compare-and-shift
// cells that keeps them sorted; the four-state sequencer sets the rate
// sequence: a sample that evicts the oldest one passes the remove, insert and
// result states, a sample while the window fills skips remove, a clear goes
// straight to result; one beat is in the sequencer at a time
// the result register frees the input side: the next beat is taken while a
// result waits; if the receiver stalls, the following result holds in the
// sequencer and no further beat is accepted until the register drains
// reset: length 96, window empty, sums zero, no result pending
module sliding_window_median_stats (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   operation,
	input  swms_pkg::sample_t                      offset,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [swms_pkg::CNT_W-1:0]             sample_count,
	output logic signed [swms_pkg::MED_W-1:0]      median_twice,
	output swms_pkg::sample_t                      minimum,
	output swms_pkg::sample_t                      maximum,
	output logic signed [swms_pkg::SUM_W-1:0]      window_sum,
	output logic [swms_pkg::SQ_W-1:0]              window_sum_squares,
	input  logic                                   cfg_we,
	input  logic [swms_pkg::CNT_W-1:0]             cfg_wdata
);
	import swms_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REMOVE = 4'b0010,
		ST_INSERT = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   window_length_q;
	logic [CNT_W-1:0]   fill_q;
	logic [IDX_W-1:0]   wp_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]    sq_q;
	sample_t            sample_q;
	sample_t            ring_rd_q;
	sample_t            ring_mem [MAX_WINDOW];

	logic               out_valid_q;
	logic [CNT_W-1:0]   count_q;
	logic signed [MED_W-1:0] median_q;
	sample_t            min_q;
	sample_t            max_q;
	logic [SUM_W-1:0]   wsum_q;
	logic [SQ_W-1:0]    wsq_q;

	logic [CNT_W-1:0]   active_len;
	logic               in_fire;
	logic               out_free;
	logic [CNT_W-1:0]   wp_inc;
	sample_t            mul_in;
	logic signed [PROD_W-1:0] prod;
	logic [SQ_W-1:0]    sq_term;
	cell_ctrl_t         ctrl;
	sample_t            min_val;
	sample_t            max_val;
	sample_t            mid_lo;
	sample_t            mid_hi;

	always_comb begin
		if (window_length_q == '0) begin
			active_len = CNT_W'(1);
		end else if (window_length_q > CNT_W'(MAX_WINDOW)) begin
			active_len = CNT_W'(MAX_WINDOW);
		end else begin
			active_len = window_length_q;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign wp_inc   = {1'b0, wp_q} + CNT_W'(1);

	// one shared squarer: evicted value, then the new sample
	assign mul_in  = (state_q == ST_REMOVE) ? ring_rd_q : sample_q;
	assign prod    = mul_in * mul_in;
	assign sq_term = SQ_W'($unsigned(prod));

	assign ctrl.remove = (state_q == ST_REMOVE);
	assign ctrl.insert = (state_q == ST_INSERT);
	assign ctrl.key    = mul_in;

	swms_chain u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.fill    (fill_q),
		.min_val (min_val),
		.max_val (max_val),
		.mid_lo  (mid_lo),
		.mid_hi  (mid_hi)
	);

	// ring read runs every cycle; the address is stable from accept to removal
	always_ff @(posedge clk) begin
		if (state_q == ST_INSERT) begin
			ring_mem[wp_q] <= sample_q;
		end
		ring_rd_q <= ring_mem[wp_q];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			window_length_q <= LEN_RESET;
			fill_q          <= '0;
			wp_q            <= '0;
			sum_q           <= '0;
			sq_q            <= '0;
		end else if (cfg_we) begin
			window_length_q <= cfg_wdata;
			fill_q          <= '0;
			wp_q            <= '0;
			sum_q           <= '0;
			sq_q            <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (op_t'(operation) == OP_CLEAR) begin
							fill_q  <= '0;
							wp_q    <= '0;
							sum_q   <= '0;
							sq_q    <= '0;
							state_q <= ST_RESULT;
						end else if (fill_q >= active_len) begin
							state_q <= ST_REMOVE;
						end else begin
							state_q <= ST_INSERT;
						end
					end
				end
				ST_REMOVE: begin
					fill_q  <= fill_q - CNT_W'(1);
					sum_q   <= sum_q - SUM_W'(ring_rd_q);
					sq_q    <= sq_q - sq_term;
					state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					fill_q  <= fill_q + CNT_W'(1);
					sum_q   <= sum_q + SUM_W'(sample_q);
					sq_q    <= sq_q + sq_term;
					wp_q    <= (wp_inc >= active_len) ? '0 : wp_inc[IDX_W-1:0];
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			count_q <= fill_q;
			wsum_q  <= sum_q;
			wsq_q   <= sq_q;
			if (fill_q == '0) begin
				median_q <= '0;
				min_q    <= '0;
				max_q    <= '0;
			end else begin
				median_q <= MED_W'(mid_lo) + MED_W'(mid_hi);
				min_q    <= min_val;
				max_q    <= max_val;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign sample_count       = count_q;
	assign median_twice       = median_q;
	assign minimum            = min_q;
	assign maximum            = max_q;
	assign window_sum         = wsum_q;
	assign window_sum_squares = wsq_q;

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= active_len)
		else $error("fill count exceeds window length");

	a_wp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wp_q} < active_len)
		else $error("write pointer outside window");

	a_remove_then_insert: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REMOVE && !cfg_we |=> state_q == ST_INSERT)
		else $error("eviction not followed by insertion");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && op_t'(operation) == OP_CLEAR |=> fill_q == '0 && state_q == ST_RESULT)
		else $error("clear did not empty the window");

endmodule

// ===== test/sliding_window_median_stats_test.sv =====
module sliding_window_median_stats_test;
	timeunit 1ns;
	timeprecision 1ps;

	import swms_pkg::*;

	localparam int CYCLE_LIMIT = 900000;
	localparam int PRINT_CAP = 40;
	localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam sample_t S_MAX = ~S_MIN;

	typedef struct {
		logic [CNT_W-1:0]        count;
		logic signed [MED_W-1:0] med;
		sample_t                 lo;
		sample_t                 hi;
		logic signed [SUM_W-1:0] total;
		logic [SQ_W-1:0]         squares;
	} stats_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    operation;
	sample_t                 offset;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [CNT_W-1:0]        sample_count;
	logic signed [MED_W-1:0] median_twice;
	sample_t                 minimum;
	sample_t                 maximum;
	logic signed [SUM_W-1:0] window_sum;
	logic [SQ_W-1:0]         window_sum_squares;
	logic                    cfg_we;
	logic [CNT_W-1:0]        cfg_wdata;

	sliding_window_median_stats u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.operation          (operation),
		.offset             (offset),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.sample_count       (sample_count),
		.median_twice       (median_twice),
		.minimum            (minimum),
		.maximum            (maximum),
		.window_sum         (window_sum),
		.window_sum_squares (window_sum_squares),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata)
	);

	// model of the window
	logic [CNT_W-1:0] window_len;
	sample_t          arrival_slots [MAX_WINDOW];
	sample_t          ordered_vals [MAX_WINDOW];
	int unsigned      slot_ptr;
	int unsigned      held;
	logic [SUM_W-1:0] total_acc;
	logic [SQ_W-1:0]  squares_acc;

	stats_t pending_stats [$];
	int     errors = 0;
	int     cycles = 0;
	bit     quiet = 1'b0;
	int     stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void empty_window();
		slot_ptr = 0;
		held = 0;
		total_acc = '0;
		squares_acc = '0;
	endfunction

	function automatic longint square(sample_t v);
		return longint'(v) * longint'(v);
	endfunction

	function automatic stats_t compute_stats(op_t op, sample_t v);
		stats_t      s;
		int unsigned len;
		int unsigned pos;
		int unsigned i;
		sample_t     old;
		longint      med;
		len = window_len;
		if (len < 1) len = 1;
		if (len > MAX_WINDOW) len = MAX_WINDOW;
		if (op == OP_CLEAR) begin
			empty_window();
		end else begin
			if (slot_ptr >= len) slot_ptr = 0;
			if (held >= len) begin
				// evict the oldest sample from the sorted order and the sums
				old = arrival_slots[slot_ptr];
				pos = 0;
				while (pos < held && ordered_vals[pos] != old) pos++;
				for (i = pos; i + 1 < held; i++) ordered_vals[i] = ordered_vals[i + 1];
				held--;
				total_acc -= SUM_W'(old);
				squares_acc -= SQ_W'(square(old));
			end
			arrival_slots[slot_ptr] = v;
			// equal samples: the new one goes after them
			pos = held;
			for (i = 0; i < held; i++) begin
				if (ordered_vals[i] > v) begin
					pos = i;
					break;
				end
			end
			for (i = held; i > pos; i--) ordered_vals[i] = ordered_vals[i - 1];
			ordered_vals[pos] = v;
			held++;
			total_acc += SUM_W'(v);
			squares_acc += SQ_W'(square(v));
			slot_ptr++;
			if (slot_ptr >= len) slot_ptr = 0;
		end
		med = 0;
		s.lo = '0;
		s.hi = '0;
		if (held > 0) begin
			s.lo = ordered_vals[0];
			s.hi = ordered_vals[held - 1];
			if (held % 2 == 1) begin
				med = 2 * longint'(ordered_vals[held / 2]);
			end else begin
				med = longint'(ordered_vals[held / 2 - 1]) + longint'(ordered_vals[held / 2]);
			end
		end
		s.count = CNT_W'(held);
		s.med = MED_W'(med);
		s.total = total_acc;
		s.squares = squares_acc;
		return s;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic sample_t random_sample();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) == 1) ? S_MAX : S_MIN;
			// narrow range so that equal samples are common
			1, 2, 3: return sample_t'(int'($urandom_range(0, 15)) - 8);
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic report(string msg);
		errors++;
		if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
	endtask

	task automatic check_field(string name, logic signed [63:0] got, logic signed [63:0] want);
		if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic send_item(op_t op, sample_t v);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		offset <= v;
		do @(posedge clk); while (!in_ready);
		pending_stats.push_back(compute_stats(op, v));
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			offset <= sample_t'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
	endtask

	task automatic set_length(logic [CNT_W-1:0] len);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= CNT_W'($urandom);
		window_len = len;
		empty_window();
	endtask

	task automatic test_directed();
		// clear on an empty window, offset ignored
		send_item(OP_CLEAR, 24'sh123456);
		send_item(OP_ADD, S_MAX);
		send_item(OP_ADD, S_MIN);
		send_item(OP_ADD, 24'sd0);
		send_item(OP_ADD, 24'sd0);
		send_item(OP_ADD, -24'sd1);
		send_item(OP_ADD, 24'sd5);
		send_item(OP_ADD, 24'sd5);
		send_item(OP_ADD, 24'sd5);
		send_item(OP_CLEAR, S_MIN);
		send_item(OP_ADD, -24'sd1);
		send_item(OP_ADD, 24'sd1);
	endtask

	task automatic test_length_edges();
		// zero acts as one: every sample replaces the last
		set_length(9'd0);
		send_item(OP_ADD, 24'sd10);
		send_item(OP_ADD, -24'sd20);
		send_item(OP_ADD, 24'sd30);
		set_length(9'd2);
		send_item(OP_ADD, S_MAX);
		send_item(OP_ADD, S_MAX);
		send_item(OP_ADD, S_MIN);
		// above the maximum acts as the maximum
		set_length(9'h1FF);
		send_item(OP_ADD, S_MIN);
		send_item(OP_ADD, S_MIN);
		send_item(OP_ADD, S_MAX);
		send_item(OP_CLEAR, 24'sd0);
		send_item(OP_ADD, S_MAX);
	endtask

	task automatic random_phase(logic [CNT_W-1:0] len, int items, int clear_odds, bit calm);
		set_length(len);
		quiet = calm;
		repeat (items) begin
			send_item(($urandom_range(1, clear_odds) == 1) ? OP_CLEAR : OP_ADD, random_sample());
		end
		quiet = 1'b0;
	endtask

	task automatic test_random();
		random_phase(9'd256, 620, 1000, 1'b0);
		random_phase(9'd1, 80, 30, 1'b0);
		random_phase(9'd2, 80, 30, 1'b0);
		random_phase(9'd0, 50, 30, 1'b0);
		random_phase(9'h1FF, 300, 1000, 1'b1);
		random_phase(9'd3, 100, 40, 1'b1);
		repeat (4) random_phase(CNT_W'($urandom_range(1, 300)), 100, 60, 1'b0);
	endtask

	// receiver with random stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin : check_results
		stats_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_stats.size() == 0) begin
				report($sformatf("result beat with nothing pending, count %0d", sample_count));
			end else begin
				want = pending_stats.pop_front();
				check_field("sample_count", 64'(sample_count), 64'(want.count));
				check_field("median_twice", 64'(median_twice), 64'(want.med));
				check_field("minimum", 64'(minimum), 64'(want.lo));
				check_field("maximum", 64'(maximum), 64'(want.hi));
				check_field("window_sum", 64'(window_sum), 64'(want.total));
				check_field("window_sum_squares", 64'(window_sum_squares),
					64'(want.squares));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = 1'b0;
		offset = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		window_len = LEN_RESET;
		empty_window();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_length_edges();
		test_random();
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
